FILE: src/ksb_pkg.sv
// Shared constants, types and helpers for the keyboard scancode buffer.
`default_nettype none
package ksb_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam logic [7:0] RELEASE_BIT = 8'h80;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_PRESS   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_ACK     = 2'd3
  } ksb_mode_t;

  // Operations requested of the ring for one item.
  typedef struct packed {
    logic       pop;
    logic       pfx_en;
    logic [7:0] pfx;
    logic       key_en;
    logic [7:0] key;
  } ksb_ring_req_t;

  // What the ring reports back.
  typedef struct packed {
    logic [7:0]       head;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] fill_nxt;
  } ksb_ring_stat_t;

  // Folds a sum below twice the depth back into the ring.
  function automatic logic [IDX_W-1:0] ring_wrap(input logic [IDX_W:0] sum);
    logic [IDX_W:0] adj;
    adj = sum;
    if (sum >= (IDX_W + 1)'(RING_DEPTH)) begin
      adj = sum - (IDX_W + 1)'(RING_DEPTH);
    end
    return adj[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/ksb_ring.sv
// Byte ring with read index and fill count; drops bytes when full.
`default_nettype none
module ksb_ring import ksb_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ksb_ring_req_t  req,
  output ksb_ring_stat_t      stat
);

  logic [7:0]       store [RING_DEPTH];
  logic [7:0]       head_r;
  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] fill_a;
  logic             pfx_ok, key_ok;
  logic [IDX_W-1:0] slot0, slot1, key_slot;

  // Each byte is checked against the space left after the one before it.
  always_comb begin
    pfx_ok   = req.pfx_en && (fill_r < CNT_W'(RING_DEPTH));
    fill_a   = fill_r + CNT_W'(pfx_ok);
    key_ok   = req.key_en && (fill_a < CNT_W'(RING_DEPTH));
    slot0    = ring_wrap({1'b0, rd_r} + (IDX_W + 1)'(fill_r));
    slot1    = ring_wrap({1'b0, rd_r} + (IDX_W + 1)'(fill_a));
    key_slot = pfx_ok ? slot1 : slot0;
    rd_nxt   = rd_r;
    fill_nxt = fill_a + CNT_W'(key_ok);
    if (req.pop) begin
      rd_nxt   = ring_wrap({1'b0, rd_r} + (IDX_W + 1)'(1));
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pfx_ok) begin
      store[slot0] <= req.pfx;
    end
    if (key_ok) begin
      store[key_slot] <= req.key;
    end
  end

  // The oldest byte is read ahead into head_r; a byte written into an empty
  // ring lands at the new read index and is passed straight through.
  always_ff @(posedge clk) begin
    if (pfx_ok && (slot0 == rd_nxt)) begin
      head_r <= req.pfx;
    end else if (key_ok && (key_slot == rd_nxt)) begin
      head_r <= req.key;
    end else begin
      head_r <= store[rd_nxt];
    end
  end

  assign stat.head     = head_r;
  assign stat.fill     = fill_r;
  assign stat.fill_nxt = fill_nxt;

endmodule
`default_nettype wire

FILE: src/keyboard_scancode_buffer.sv
// Top level of the keyboard scancode buffer: input register, event decode, result register.
//
//   channel   ports                                    handshake
//   input     in_mode, in_scancode                     start high, busy low
//   result    out_delivered .. out_awaiting_ack        out_valid for one cycle
//
// Every item passes the input register and the result register on its way to
// its result, and one item is accepted in every cycle; busy never rises.
// The ring update and the flag update sit in the single stage between the
// input register and the result register.
// Reset clears the pointers, fill count, flags and data port; ring contents
// are left as they are. The receiver cannot stall, so each result beat is shown once.
`default_nettype none
module keyboard_scancode_buffer import ksb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_scancode,
  output logic             out_valid,
  output logic             out_delivered,
  output logic [7:0]       out_port_byte,
  output logic             out_output_full,
  output logic             out_irq_pulse,
  output logic [4:0]       out_queued_count,
  output logic             out_awaiting_ack
);

  logic           vld_r;
  ksb_mode_t      mode_r;
  logic [15:0]    code_r;
  logic           ack_r, ack_nxt;
  logic           full_r, full_nxt;
  logic [7:0]     port_r, port_nxt;
  logic           is_key, is_rel, pop;
  ksb_ring_req_t  req;
  ksb_ring_stat_t stat;

  logic           ov_r;
  logic           odel_r;
  logic [7:0]     obyte_r;
  logic           ofull_r;
  logic [4:0]     ocnt_r;
  logic           oack_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mode_r <= ksb_mode_t'(in_mode);
      code_r <= in_scancode;
    end
  end

  always_comb begin
    is_key     = vld_r && (mode_r == MODE_PRESS || mode_r == MODE_RELEASE);
    is_rel     = (mode_r == MODE_RELEASE);
    pop        = vld_r && (mode_r == MODE_TICK) && !ack_r && (stat.fill != '0);
    req.pop    = pop;
    req.pfx_en = is_key && (code_r[15:8] != 8'h00);
    req.pfx    = code_r[15:8];
    req.key_en = is_key;
    req.key    = code_r[7:0] | (is_rel ? RELEASE_BIT : 8'h00);
    ack_nxt    = ack_r;
    full_nxt   = full_r;
    port_nxt   = port_r;
    if (pop) begin
      ack_nxt  = 1'b1;
      full_nxt = 1'b1;
      port_nxt = stat.head;
    end else if (vld_r && mode_r == MODE_ACK) begin
      ack_nxt  = 1'b0;
      full_nxt = 1'b0;
    end
  end

  ksb_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_r  <= 1'b0;
      full_r <= 1'b0;
      port_r <= 8'h00;
      ov_r   <= 1'b0;
    end else begin
      ack_r  <= ack_nxt;
      full_r <= full_nxt;
      port_r <= port_nxt;
      ov_r   <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    odel_r  <= pop;
    obyte_r <= port_nxt;
    ofull_r <= full_nxt;
    ocnt_r  <= 5'(stat.fill_nxt);
    oack_r  <= ack_nxt;
  end

  assign out_valid        = ov_r;
  assign out_delivered    = odel_r;
  assign out_port_byte    = obyte_r;
  assign out_output_full  = ofull_r;
  assign out_irq_pulse    = odel_r;
  assign out_queued_count = ocnt_r;
  assign out_awaiting_ack = oack_r;

endmodule
`default_nettype wire
